[rtl/core/charge_stage_selector_top_assert.svh]
// Assertion macros for the charge stage selector.
// Both expect clk and rst_n in scope.
`ifndef CHARGE_STAGE_SELECTOR_TOP_ASSERT_SVH
`define CHARGE_STAGE_SELECTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/css_pkg.sv]
`timescale 1ns / 1ps

package css_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIMER_W  = 8;
  localparam int unsigned TCOUNT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // default tuning
  localparam int unsigned TRICKLE_SECONDS_DEF     = 60;
  localparam int unsigned FLOAT_DELAY_SECONDS_DEF = 60;
  localparam int unsigned TAPER_STEP_DEF          = 8;
  localparam int unsigned TAPER_MIN_DEF           = 64;

  // ticks per taper step, and margin below float voltage where taper may run
  localparam int unsigned TAPER_TICKS  = 25;
  localparam int unsigned TAPER_MARGIN = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_VOLTAGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_VOLTAGE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_CV_VOLTAGE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_VOLTAGE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_CURRENT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_CURRENT          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_ENTRY_CURRENT = 3'd6;

  typedef enum logic [1:0] {
    STAGE_TRICKLE = 2'd0,
    STAGE_CC      = 2'd1,
    STAGE_TAPER   = 2'd2,
    STAGE_NONE    = 2'd3
  } stage_t;

endpackage

[rtl/core/charge_stage_selector_top.sv]
`timescale 1ns / 1ps

// Charge stage selector for a CC/CV charger. Each item is one control tick
// (battery voltage and current samples, voltage loop demand, one-second flag);
// each tick gives exactly one result: current reference, clamped voltage
// reference, charge stage (trickle, constant current, taper, or none) and the
// sticky float flag. A tick goes into the input register on acceptance and its
// result into the output register when that is empty or not stalled. One item
// is taken every cycle while the output is not stalled; the charger state
// (timers, taper counter, references, flags) is updated from the input register
// as the result is registered. An output stall holds the output register, and
// the input is stalled only once the input register is also full. Thresholds
// must be written via the cfg port while the block is idle; this is unchecked.

`include "charge_stage_selector_top_assert.svh"

module charge_stage_selector_top #(
  parameter int unsigned TRICKLE_SECONDS     = css_pkg::TRICKLE_SECONDS_DEF,
  parameter int unsigned FLOAT_DELAY_SECONDS = css_pkg::FLOAT_DELAY_SECONDS_DEF,
  parameter int unsigned TAPER_STEP          = css_pkg::TAPER_STEP_DEF,
  parameter int unsigned TAPER_MIN           = css_pkg::TAPER_MIN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [css_pkg::SAMPLE_W-1:0]        cfg_wdata,
  // ticks in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [css_pkg::SAMPLE_W-1:0]        in_vbat_sample,
  input  logic [css_pkg::SAMPLE_W-1:0]        in_ibat_sample,
  input  logic [css_pkg::SAMPLE_W-1:0]        in_vloop_out,
  input  logic                                in_second_elapsed,
  // results out
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [css_pkg::SAMPLE_W-1:0]        out_current_ref,
  output logic [css_pkg::SAMPLE_W-1:0]        out_voltage_ref,
  output logic [1:0]                          out_charge_stage,
  output logic                                out_float_active
);

  localparam int unsigned SW = css_pkg::SAMPLE_W;
  localparam int unsigned TW = css_pkg::TIMER_W;
  localparam int unsigned CW = css_pkg::TCOUNT_W;

  // configuration registers
  logic [SW-1:0] trickle_voltage_r, float_voltage_r, cc_cv_voltage_r, cv_voltage_r;
  logic [SW-1:0] trickle_current_r, cc_current_r, float_entry_current_r;

  // input register
  logic          s1_valid_r;
  logic [SW-1:0] vbat_r, ibat_r, vloop_r;
  logic          sec_r;

  // charger state
  logic [TW-1:0] trickle_timer_r, trickle_timer_nxt;
  logic          cc_entered_r, cc_entered_nxt;
  logic          taper_entered_r, taper_entered_nxt;
  logic [CW-1:0] taper_count_r, taper_count_nxt;
  logic [SW-1:0] current_ref_r, current_ref_nxt;
  logic [TW-1:0] float_timer_r, float_timer_nxt;
  logic          float_flag_r, float_flag_nxt;
  logic [SW-1:0] voltage_ref_r, voltage_ref_nxt;

  // output register
  logic                 out_valid_r;
  logic [SW-1:0]        out_current_ref_r, out_voltage_ref_r;
  css_pkg::stage_t      out_stage_r, stage_nxt;
  logic                 out_float_r;

  logic s1_adv, in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trickle_voltage_r     <= '0;
      float_voltage_r       <= '0;
      cc_cv_voltage_r       <= '0;
      cv_voltage_r          <= '0;
      trickle_current_r     <= '0;
      cc_current_r          <= '0;
      float_entry_current_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        css_pkg::CFG_TRICKLE_VOLTAGE:     trickle_voltage_r     <= cfg_wdata;
        css_pkg::CFG_FLOAT_VOLTAGE:       float_voltage_r       <= cfg_wdata;
        css_pkg::CFG_CC_CV_VOLTAGE:       cc_cv_voltage_r       <= cfg_wdata;
        css_pkg::CFG_CV_VOLTAGE:          cv_voltage_r          <= cfg_wdata;
        css_pkg::CFG_TRICKLE_CURRENT:     trickle_current_r     <= cfg_wdata;
        css_pkg::CFG_CC_CURRENT:          cc_current_r          <= cfg_wdata;
        css_pkg::CFG_FLOAT_ENTRY_CURRENT: float_entry_current_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage selection and state update for the tick in the input register
  logic          trickle_sel, cc_sel, taper_sel;
  logic [CW:0]   taper_count_inc;
  logic          float_cond;
  logic [TW-1:0] float_timer_inc;
  logic [SW-1:0] ref_minus_step;

  always_comb begin
    trickle_sel = (vbat_r < trickle_voltage_r ||
                   {1'b0, trickle_timer_r} < (TW+1)'(TRICKLE_SECONDS)) && !cc_entered_r;
    cc_sel      = vbat_r < float_voltage_r && !taper_entered_r;
    taper_sel   = ({1'b0, vbat_r} + (SW+1)'(css_pkg::TAPER_MARGIN) >= {1'b0, float_voltage_r})
                  && vloop_r < cc_current_r;

    trickle_timer_nxt = trickle_timer_r;
    cc_entered_nxt    = cc_entered_r;
    taper_entered_nxt = taper_entered_r;
    taper_count_nxt   = taper_count_r;
    current_ref_nxt   = current_ref_r;
    stage_nxt         = css_pkg::STAGE_NONE;
    taper_count_inc   = {1'b0, taper_count_r} + (CW+1)'(1);
    ref_minus_step    = current_ref_r - SW'(TAPER_STEP);

    if (trickle_sel) begin
      // timer stops one past the limit and never wraps
      if (sec_r && {1'b0, trickle_timer_r} <= (TW+1)'(TRICKLE_SECONDS) &&
          trickle_timer_r != {TW{1'b1}})
        trickle_timer_nxt = trickle_timer_r + TW'(1);
      current_ref_nxt = trickle_current_r;
      stage_nxt       = css_pkg::STAGE_TRICKLE;
    end else if (cc_sel) begin
      current_ref_nxt = cc_current_r;
      cc_entered_nxt  = 1'b1;
      stage_nxt       = css_pkg::STAGE_CC;
    end else if (taper_sel) begin
      stage_nxt       = css_pkg::STAGE_TAPER;
      taper_count_nxt = taper_count_inc[CW-1:0];
      if (taper_count_inc >= (CW+1)'(css_pkg::TAPER_TICKS)) begin
        taper_count_nxt   = '0;
        taper_entered_nxt = 1'b1;
        if (current_ref_r < SW'(TAPER_STEP) || ref_minus_step < SW'(TAPER_MIN))
          current_ref_nxt = SW'(TAPER_MIN);
        else
          current_ref_nxt = ref_minus_step;
      end
    end

    float_cond      = vbat_r >= cc_cv_voltage_r && ibat_r < float_entry_current_r;
    float_timer_inc = (float_timer_r != {TW{1'b1}}) ? float_timer_r + TW'(1) : float_timer_r;
    float_timer_nxt = float_timer_r;
    float_flag_nxt  = float_flag_r;
    voltage_ref_nxt = voltage_ref_r;
    if (float_cond) begin
      if (sec_r) begin
        float_timer_nxt = float_timer_inc;
        if (float_timer_inc >= TW'(FLOAT_DELAY_SECONDS)) begin
          voltage_ref_nxt = float_voltage_r;
          float_flag_nxt  = 1'b1;
        end
      end
    end else begin
      float_timer_nxt = '0;
    end

    if (!float_flag_nxt)
      voltage_ref_nxt = cv_voltage_r;
    if (voltage_ref_nxt > cv_voltage_r)
      voltage_ref_nxt = cv_voltage_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      trickle_timer_r <= '0;
      cc_entered_r    <= 1'b0;
      taper_entered_r <= 1'b0;
      taper_count_r   <= '0;
      current_ref_r   <= '0;
      float_timer_r   <= '0;
      float_flag_r    <= 1'b0;
      voltage_ref_r   <= '0;
    end else begin
      if (in_acc)
        s1_valid_r <= 1'b1;
      else if (s1_adv)
        s1_valid_r <= 1'b0;

      if (s1_adv)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;

      if (s1_adv) begin
        trickle_timer_r <= trickle_timer_nxt;
        cc_entered_r    <= cc_entered_nxt;
        taper_entered_r <= taper_entered_nxt;
        taper_count_r   <= taper_count_nxt;
        current_ref_r   <= current_ref_nxt;
        float_timer_r   <= float_timer_nxt;
        float_flag_r    <= float_flag_nxt;
        voltage_ref_r   <= voltage_ref_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vbat_r  <= in_vbat_sample;
      ibat_r  <= in_ibat_sample;
      vloop_r <= in_vloop_out;
      sec_r   <= in_second_elapsed;
    end
    if (s1_adv) begin
      out_current_ref_r <= current_ref_nxt;
      out_voltage_ref_r <= voltage_ref_nxt;
      out_stage_r       <= stage_nxt;
      out_float_r       <= float_flag_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_ref  = out_current_ref_r;
  assign out_voltage_ref  = out_voltage_ref_r;
  assign out_charge_stage = out_stage_r;
  assign out_float_active = out_float_r;

  `CSS_ASSERT_NEXT(a_float_sticky, float_flag_r, float_flag_r, "float flag cleared")
  `CSS_ASSERT_NOW(a_taper_count_bound, 1'b1,
                  taper_count_r < CW'(css_pkg::TAPER_TICKS), "taper count past wrap")
  `CSS_ASSERT_NOW(a_trickle_timer_bound, 1'b1,
                  {1'b0, trickle_timer_r} <= (TW+1)'(TRICKLE_SECONDS) + (TW+1)'(1),
                  "trickle timer past limit")
  `CSS_ASSERT_NOW(a_accept_room, in_valid && !in_stall, !s1_valid_r || s1_adv,
                  "item accepted over a held item")

endmodule
